// File: hdl/gmu_pkg.sv
// Package for the packed upper-triangle Gram matrix block.
// Holds field widths, register indexes, reset values and the MAC control struct.
// No dependencies.
`default_nettype none

package gmu_pkg;

  localparam int DOT_BITS       = 38;
  localparam int ROW_FIELD_BITS = 5;
  localparam int ADDR_BITS_OUT  = 10;
  localparam int ROW_COUNT_BITS = 6;
  localparam int COL_COUNT_BITS = 7;
  localparam int CFG_DATA_BITS  = 7;
  localparam int CFG_INDEX_BITS = 2;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  localparam cfg_index_t REG_ROW_COUNT    = 2'd0;
  localparam cfg_index_t REG_COLUMN_COUNT = 2'd1;

  localparam logic [ROW_COUNT_BITS-1:0] ROW_COUNT_RESET    = 6'd32;
  localparam logic [COL_COUNT_BITS-1:0] COLUMN_COUNT_RESET = 7'd64;

  // Tags that travel with each operand pair through the MAC pipeline
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

`default_nettype wire

// File: hdl/gmu_ram.sv
// Generic simple RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module gmu_ram #(
  parameter int WIDTH     = 16,
  parameter int DEPTH     = 2048,
  parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_BITS-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]     wr_data,
  input  wire logic                 rd_en,
  input  wire logic [ADDR_BITS-1:0] rd_addr_a,
  input  wire logic [ADDR_BITS-1:0] rd_addr_b,
  output logic      [WIDTH-1:0]     rd_data_a,
  output logic      [WIDTH-1:0]     rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

`default_nettype wire

// File: hdl/gmu_mac.sv
// Shared multiply-accumulate unit: product register, then wide accumulator.
// Operands arrive in the cycle after their tags (registered RAM read). Uses gmu_pkg.
`default_nettype none

module gmu_mac
  import gmu_pkg::*;
#(
  parameter int ELEMENT_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire mac_ctl_t                       issue,
  input  wire logic signed [ELEMENT_BITS-1:0] data_a,
  input  wire logic signed [ELEMENT_BITS-1:0] data_b,
  output logic             [DOT_BITS-1:0]     acc_out,
  output logic                                done
);

  localparam int PROD_BITS = 2 * ELEMENT_BITS;
  localparam int ACC_BITS  = (PROD_BITS > DOT_BITS) ? PROD_BITS : DOT_BITS;

  mac_ctl_t                    ctl_rd;
  mac_ctl_t                    ctl_prod;
  logic signed [PROD_BITS-1:0] prod;
  logic signed [ACC_BITS-1:0]  acc;
  logic signed [ACC_BITS-1:0]  prod_ext;

  assign prod_ext = ACC_BITS'(prod);
  assign acc_out  = acc[DOT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_rd   <= '0;
      ctl_prod <= '0;
      done     <= 1'b0;
    end else begin
      ctl_rd   <= issue;
      ctl_prod <= ctl_rd;
      done     <= ctl_prod.valid && ctl_prod.last;
    end
    if (ctl_rd.valid) begin
      prod <= data_a * data_b;
    end
    if (ctl_prod.valid) begin
      acc <= ctl_prod.first ? prod_ext : acc + prod_ext;
    end
  end

endmodule

`default_nettype wire

// File: hdl/gram_matrix_upper_packed.sv
// Top level of the packed upper-triangle Gram matrix block (A times A transposed).
// Sequencer, row store (gmu_ram) and shared MAC (gmu_mac). Uses gmu_pkg.
//
// Usage: matrix elements enter row-major on element/in_valid; in_stall is low
// while the block waits for an element. Each element is written to the row
// store. When the last element of row j arrives, the block computes j+1
// dot products, row i against row j for i = 0..j, and presents each on the
// output channel (out_valid, held while out_stall is high) with i, j, the
// packed upper-triangle address, last_of_run on i == j and matrix_done on
// the final result of the matrix.
// Elements that do not end a row are accepted back to back. At a row end
// every dot product runs M operand pairs through the single MAC (registered
// read, product register, accumulator), then loads the output register.
// in_stall is high for the whole run of a row end, and longer if the
// receiver stalls a result.
// A result may sit in the output register while new elements are accepted.
// Reset (synchronous) sets N = 32, M = 64 and restarts at row 0, column 0; the
// row store is not cleared. Any register write also restarts the matrix.
// Registers are written only while the block is idle.
`default_nettype none

module gram_matrix_upper_packed
  import gmu_pkg::*;
#(
  parameter int ROWS_MAX     = 32,
  parameter int COLS_MAX     = 64,
  parameter int ELEMENT_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write_en,
  input  wire cfg_index_t                      cfg_index,
  input  wire logic        [CFG_DATA_BITS-1:0] cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic signed [ELEMENT_BITS-1:0]  element,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed      [DOT_BITS-1:0]      dot_product,
  output logic             [ROW_FIELD_BITS-1:0] first_row,
  output logic             [ROW_FIELD_BITS-1:0] second_row,
  output logic             [ADDR_BITS_OUT-1:0] packed_address,
  output logic                                 last_of_run,
  output logic                                 matrix_done
);

  localparam int DEPTH = ROWS_MAX * COLS_MAX;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RIW   = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
  localparam int KW    = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1;
  localparam int NW    = $clog2(ROWS_MAX + 1);
  localparam int MW    = $clog2(COLS_MAX + 1);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT, S_EMIT} state_t;

  state_t                    state;
  logic [ROW_COUNT_BITS-1:0] row_count;
  logic [COL_COUNT_BITS-1:0] column_count;
  logic [NW-1:0]             n_rows;
  logic [MW-1:0]             m_cols;

  logic [RIW-1:0]           cur_row;
  logic [KW-1:0]            col;
  logic [AW-1:0]            row_base_j;
  logic [RIW-1:0]           i_row;
  logic [AW-1:0]            row_base_i;
  logic [KW-1:0]            k;
  logic [AW-1:0]            addr_a;
  logic [AW-1:0]            addr_b;
  logic [ADDR_BITS_OUT-1:0] pack_addr;

  logic                          in_fire;
  logic                          row_end;
  logic                          last_row;
  logic                          out_free;
  mac_ctl_t                      issue;
  logic [ELEMENT_BITS-1:0]       rd_a;
  logic [ELEMENT_BITS-1:0]       rd_b;
  logic [DOT_BITS-1:0]           acc;
  logic                          mac_done;

  // Register values saturated into the supported range
  always_comb begin
    if (row_count == '0) begin
      n_rows = NW'(1);
    end else if (int'(row_count) > ROWS_MAX) begin
      n_rows = NW'(ROWS_MAX);
    end else begin
      n_rows = NW'(row_count);
    end
    if (column_count == '0) begin
      m_cols = MW'(1);
    end else if (int'(column_count) > COLS_MAX) begin
      m_cols = MW'(COLS_MAX);
    end else begin
      m_cols = MW'(column_count);
    end
  end

  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign row_end  = !((MW'(col) + MW'(1)) < m_cols);
  assign last_row = !((NW'(cur_row) + NW'(1)) < n_rows);
  assign out_free = !out_valid || !out_stall;

  assign issue.valid = (state == S_RUN);
  assign issue.first = (k == '0);
  assign issue.last  = (MW'(k) == m_cols - MW'(1));

  gmu_ram #(
    .WIDTH (ELEMENT_BITS),
    .DEPTH (DEPTH)
  ) u_row_store (
    .clk       (clk),
    .wr_en     (in_fire),
    .wr_addr   (row_base_j + AW'(col)),
    .wr_data   (element),
    .rd_en     (issue.valid),
    .rd_addr_a (addr_a),
    .rd_addr_b (addr_b),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  gmu_mac #(
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_mac (
    .clk     (clk),
    .rst     (rst),
    .issue   (issue),
    .data_a  (rd_a),
    .data_b  (rd_b),
    .acc_out (acc),
    .done    (mac_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      row_count    <= ROW_COUNT_RESET;
      column_count <= COLUMN_COUNT_RESET;
      cur_row      <= '0;
      col          <= '0;
      row_base_j   <= '0;
    end else begin
      // S_EMIT reloads the output register itself
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cfg_write_en) begin
            unique case (cfg_index)
              REG_ROW_COUNT: begin
                row_count  <= cfg_data[ROW_COUNT_BITS-1:0];
                cur_row    <= '0;
                col        <= '0;
                row_base_j <= '0;
              end
              REG_COLUMN_COUNT: begin
                column_count <= cfg_data[COL_COUNT_BITS-1:0];
                cur_row      <= '0;
                col          <= '0;
                row_base_j   <= '0;
              end
              default: ;
            endcase
          end else if (in_fire) begin
            if (!row_end) begin
              col <= col + KW'(1);
            end else begin
              col        <= '0;
              i_row      <= '0;
              row_base_i <= '0;
              k          <= '0;
              addr_a     <= '0;
              addr_b     <= row_base_j;
              pack_addr  <= ADDR_BITS_OUT'(cur_row);
              state      <= S_RUN;
            end
          end
        end
        S_RUN: begin
          addr_a <= addr_a + AW'(1);
          addr_b <= addr_b + AW'(1);
          k      <= k + KW'(1);
          if (issue.last) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (mac_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            dot_product    <= acc;
            first_row      <= ROW_FIELD_BITS'(i_row);
            second_row     <= ROW_FIELD_BITS'(cur_row);
            packed_address <= pack_addr;
            last_of_run    <= (i_row == cur_row);
            matrix_done    <= (i_row == cur_row) && last_row;
            if (i_row == cur_row) begin
              cur_row    <= last_row ? '0 : cur_row + RIW'(1);
              row_base_j <= last_row ? '0 : row_base_j + AW'(COLS_MAX);
              state      <= S_IDLE;
            end else begin
              i_row      <= i_row + RIW'(1);
              row_base_i <= row_base_i + AW'(COLS_MAX);
              addr_a     <= row_base_i + AW'(COLS_MAX);
              addr_b     <= row_base_j;
              k          <= '0;
              // step to next packed row: add N - i - 1
              pack_addr  <= pack_addr + ADDR_BITS_OUT'(n_rows) - ADDR_BITS_OUT'(i_row)
                            - ADDR_BITS_OUT'(1);
              state      <= S_RUN;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && matrix_done |-> last_of_run)
    else $error("matrix_done without last_of_run");

  a_run_end_diag: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_run |-> first_row == second_row)
    else $error("last_of_run off the diagonal");

  a_mac_done_wait: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> state == S_WAIT)
    else $error("MAC finished outside the wait state");

endmodule

`default_nettype wire
